@@ src/msf_pkg.sv @@
package msf_pkg;

    localparam int unsigned FAST_PERIOD   = 12;
    localparam int unsigned SLOW_PERIOD   = 26;
    localparam int unsigned SIGNAL_PERIOD = 9;

    localparam int unsigned PRICE_W    = 32;
    localparam int unsigned VAL_W      = PRICE_W + 1;
    localparam int unsigned WEIGHT_W   = 17;
    localparam int unsigned WEIGHT_ONE = 65536;

    localparam int unsigned PRICE_DEPTH =
        ((FAST_PERIOD > SLOW_PERIOD) ? FAST_PERIOD : SLOW_PERIOD) + 1;
    localparam int unsigned MACD_DEPTH  = SIGNAL_PERIOD + 1;
    localparam int unsigned COUNT_CAP   =
        (PRICE_DEPTH > MACD_DEPTH) ? PRICE_DEPTH : MACD_DEPTH;
    localparam int unsigned CNT_W       = $clog2(COUNT_CAP + 1);

    localparam int unsigned TREE_N      = COUNT_CAP;
    localparam int unsigned TREE_LVL    = $clog2(TREE_N);
    localparam int unsigned TREE_LEAVES = 1 << TREE_LVL;

    localparam int unsigned DEN_W = 22;
    localparam int unsigned NUM_W = 56;
    localparam int unsigned QW    = PRICE_W;

    localparam int unsigned DOT_LAT  = TREE_LVL + 1;
    localparam int unsigned DIV_LAT  = QW + 2;
    localparam int unsigned MACD_DLY = DOT_LAT + DIV_LAT;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } ctl_t;

    typedef logic [WEIGHT_W-1:0] weight_tab_t [TREE_N];
    typedef logic [DEN_W-1:0]    den_tab_t    [COUNT_CAP + 1];

    // long division for elaboration-time tables
    function automatic logic [63:0] const_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic weight_tab_t make_weights(input int unsigned period);
        weight_tab_t tab;
        logic [63:0] w;
        w = 64'(WEIGHT_ONE);
        for (int i = 0; i < TREE_N; i++)
        begin
            tab[i] = (i <= period) ? WEIGHT_W'(w) : '0;
            w = const_div(w * 64'(period - 1) + 64'((period + 1) >> 1), 64'(period + 1));
        end
        return tab;
    endfunction

    function automatic den_tab_t make_den(input int unsigned period);
        den_tab_t    tab;
        weight_tab_t wt;
        int unsigned lim;
        logic [63:0] acc;
        wt = make_weights(period);
        for (int c = 0; c <= COUNT_CAP; c++)
        begin
            lim = (c > period + 1) ? period + 1 : c;
            if (lim == 0)
                lim = 1;
            acc = '0;
            for (int i = 0; i < TREE_N; i++)
            begin
                if (i < lim)
                    acc = acc + 64'(wt[i]);
            end
            tab[c] = DEN_W'(acc);
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHTS_FAST   = make_weights(FAST_PERIOD);
    localparam weight_tab_t WEIGHTS_SLOW   = make_weights(SLOW_PERIOD);
    localparam weight_tab_t WEIGHTS_SIGNAL = make_weights(SIGNAL_PERIOD);
    localparam den_tab_t    DEN_FAST       = make_den(FAST_PERIOD);
    localparam den_tab_t    DEN_SLOW       = make_den(SLOW_PERIOD);
    localparam den_tab_t    DEN_SIGNAL     = make_den(SIGNAL_PERIOD);

endpackage

@@ src/msf_price_if.sv @@
interface msf_price_if;
    logic                          valid;
    logic                          ready;
    logic [msf_pkg::PRICE_W-1:0]   price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

@@ src/msf_result_if.sv @@
interface msf_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [msf_pkg::PRICE_W-1:0] macd_value;
    logic signed [msf_pkg::PRICE_W-1:0] signal_value;

    modport source (output valid, output macd_value, output signal_value, input ready);
    modport sink   (input valid, input macd_value, input signal_value, output ready);
endinterface

@@ src/msf_dot.sv @@
module msf_dot (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  msf_pkg::ctl_t                           ctl_in,
    input  logic signed [msf_pkg::VAL_W-1:0]        vals [msf_pkg::TREE_N],
    input  msf_pkg::weight_tab_t                    weights,
    output msf_pkg::ctl_t                           ctl_out,
    output logic signed [msf_pkg::NUM_W-1:0]        num
);

    logic signed [msf_pkg::NUM_W-1:0] node_reg [msf_pkg::TREE_LVL + 1][msf_pkg::TREE_LEAVES];
    msf_pkg::ctl_t                    ctl_reg  [msf_pkg::TREE_LVL + 1];

    // products of each tap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < msf_pkg::TREE_N; k++)
                node_reg[0][k] <= msf_pkg::NUM_W'(vals[k] *
                                  $signed({1'b0, weights[k]}));
            for (int k = msf_pkg::TREE_N; k < msf_pkg::TREE_LEAVES; k++)
                node_reg[0][k] <= '0;
        end
    end

    for (genvar l = 0; l < msf_pkg::TREE_LVL; l++)
    begin : g_lvl
        for (genvar k = 0; k < (msf_pkg::TREE_LEAVES >> (l + 1)); k++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                if (en)
                    node_reg[l + 1][k] <= node_reg[l][2 * k] + node_reg[l][2 * k + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l <= msf_pkg::TREE_LVL; l++)
                ctl_reg[l] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int l = 1; l <= msf_pkg::TREE_LVL; l++)
                ctl_reg[l] <= ctl_reg[l - 1];
        end
    end

    assign ctl_out = ctl_reg[msf_pkg::TREE_LVL];
    assign num     = node_reg[msf_pkg::TREE_LVL][0];

endmodule

@@ src/msf_div.sv @@
module msf_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  msf_pkg::ctl_t                      ctl_in,
    input  logic signed [msf_pkg::NUM_W-1:0]   num,
    input  logic [msf_pkg::DEN_W-1:0]          den,
    output msf_pkg::ctl_t                      ctl_out,
    output logic signed [msf_pkg::QW:0]        quot
);

    localparam int unsigned QW    = msf_pkg::QW;
    localparam int unsigned NUM_W = msf_pkg::NUM_W;

    logic [NUM_W-1:0]          rem_reg [QW + 1];
    logic [QW-1:0]             q_reg   [QW + 1];
    logic [msf_pkg::DEN_W-1:0] den_reg [QW + 1];
    logic                      neg_reg [QW + 1];
    msf_pkg::ctl_t             ctl_reg [QW + 2];
    logic signed [QW:0]        quot_reg;
    logic [NUM_W-1:0]          mag;

    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // round half away from zero: add half the divisor to the magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag + NUM_W'(den >> 1);
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NUM_W-1];
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_step
        logic [NUM_W-1:0] dsh;
        assign dsh = NUM_W'(den_reg[s - 1]) << (QW - s);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_reg[s - 1];
                neg_reg[s] <= neg_reg[s - 1];
                if (rem_reg[s - 1] >= dsh)
                begin
                    rem_reg[s] <= rem_reg[s - 1] - dsh;
                    q_reg[s]   <= q_reg[s - 1] | (QW'(1) << (QW - s));
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s - 1];
                    q_reg[s]   <= q_reg[s - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quot_reg <= neg_reg[QW] ? -$signed({1'b0, q_reg[QW]}) : $signed({1'b0, q_reg[QW]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QW + 1; s++)
                ctl_reg[s] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s <= QW + 1; s++)
                ctl_reg[s] <= ctl_reg[s - 1];
        end
    end

    assign ctl_out = ctl_reg[QW + 1];
    assign quot    = quot_reg;

endmodule

@@ src/macd_signal_filter.sv @@
// One fixed path from an accepted request to its result: input stage, weighted-sum tree,
// 34-stage divider, MACD stage, sum tree, divider.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, async, active low) clears valid bits, sample count and both
// history lines; no clearing pass is needed.
module macd_signal_filter (
    input  logic                clk,
    input  logic                rst_n,
    msf_price_if.sink           samples,
    msf_result_if.source        results
);

    localparam int unsigned VAL_W = msf_pkg::VAL_W;
    localparam logic signed [VAL_W:0] SAT_HI =
        (VAL_W + 1)'((64'sd1 <<< (msf_pkg::PRICE_W - 1)) - 64'sd1);
    localparam logic signed [VAL_W:0] SAT_LO = -SAT_HI - 1;

    logic                                en;
    logic                                accept;
    logic [msf_pkg::PRICE_W-1:0]         price_hist_reg [msf_pkg::PRICE_DEPTH];
    logic [msf_pkg::CNT_W-1:0]           count_reg;
    msf_pkg::ctl_t                       s0_ctl_reg;
    logic signed [VAL_W-1:0]             price_vals [msf_pkg::TREE_N];

    msf_pkg::ctl_t                       fdot_ctl;
    logic signed [msf_pkg::NUM_W-1:0]    fast_num;
    logic signed [msf_pkg::NUM_W-1:0]    slow_num;
    msf_pkg::ctl_t                       fdiv_ctl;
    logic signed [msf_pkg::QW:0]         fast_avg;
    logic signed [msf_pkg::QW:0]         slow_avg;

    logic signed [VAL_W:0]               diff;
    logic signed [msf_pkg::PRICE_W-1:0]  macd_next;
    logic signed [msf_pkg::PRICE_W-1:0]  macd_hist_reg [msf_pkg::MACD_DEPTH];
    msf_pkg::ctl_t                       mctl_reg;
    logic signed [VAL_W-1:0]             macd_vals [msf_pkg::TREE_N];
    logic signed [msf_pkg::PRICE_W-1:0]  macd_dly_reg [msf_pkg::MACD_DLY];

    msf_pkg::ctl_t                       sdot_ctl;
    logic signed [msf_pkg::NUM_W-1:0]    sig_num;
    msf_pkg::ctl_t                       sdiv_ctl;
    logic signed [msf_pkg::QW:0]         sig_avg;

    assign en            = !sdiv_ctl.valid || results.ready;
    assign samples.ready = en;
    assign accept        = samples.valid && en;

    // input stage: shift price history, count samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msf_pkg::PRICE_DEPTH; i++)
                price_hist_reg[i] <= '0;
            count_reg  <= '0;
            s0_ctl_reg <= '0;
        end
        else if (en)
        begin
            s0_ctl_reg.valid <= samples.valid;
            if (samples.valid)
            begin
                price_hist_reg[0] <= samples.price;
                for (int i = 1; i < msf_pkg::PRICE_DEPTH; i++)
                    price_hist_reg[i] <= price_hist_reg[i - 1];
                if (count_reg < msf_pkg::CNT_W'(msf_pkg::COUNT_CAP))
                begin
                    count_reg        <= count_reg + 1'b1;
                    s0_ctl_reg.count <= count_reg + 1'b1;
                end
                else
                begin
                    s0_ctl_reg.count <= count_reg;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < msf_pkg::TREE_N; i++)
        begin
            if (i < msf_pkg::PRICE_DEPTH)
                price_vals[i] = $signed({1'b0, price_hist_reg[i]});
            else
                price_vals[i] = '0;
        end
    end

    msf_dot u_fast_dot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (s0_ctl_reg),
        .vals    (price_vals),
        .weights (msf_pkg::WEIGHTS_FAST),
        .ctl_out (fdot_ctl),
        .num     (fast_num)
    );

    msf_dot u_slow_dot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (s0_ctl_reg),
        .vals    (price_vals),
        .weights (msf_pkg::WEIGHTS_SLOW),
        .ctl_out (),
        .num     (slow_num)
    );

    msf_div u_fast_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (fdot_ctl),
        .num     (fast_num),
        .den     (msf_pkg::DEN_FAST[fdot_ctl.count]),
        .ctl_out (fdiv_ctl),
        .quot    (fast_avg)
    );

    msf_div u_slow_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (fdot_ctl),
        .num     (slow_num),
        .den     (msf_pkg::DEN_SLOW[fdot_ctl.count]),
        .ctl_out (),
        .quot    (slow_avg)
    );

    // saturate the difference to the signed 32-bit range
    always_comb
    begin
        diff = (VAL_W + 1)'(fast_avg) - (VAL_W + 1)'(slow_avg);
        if (diff > SAT_HI)
            macd_next = msf_pkg::PRICE_W'(SAT_HI);
        else if (diff < SAT_LO)
            macd_next = msf_pkg::PRICE_W'(SAT_LO);
        else
            macd_next = msf_pkg::PRICE_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msf_pkg::MACD_DEPTH; i++)
                macd_hist_reg[i] <= '0;
            mctl_reg <= '0;
        end
        else if (en)
        begin
            mctl_reg <= fdiv_ctl;
            if (fdiv_ctl.valid)
            begin
                macd_hist_reg[0] <= macd_next;
                for (int i = 1; i < msf_pkg::MACD_DEPTH; i++)
                    macd_hist_reg[i] <= macd_hist_reg[i - 1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < msf_pkg::TREE_N; i++)
        begin
            if (i < msf_pkg::MACD_DEPTH)
                macd_vals[i] = VAL_W'(macd_hist_reg[i]);
            else
                macd_vals[i] = '0;
        end
    end

    // hold each MACD value until its signal average comes out
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            macd_dly_reg[0] <= macd_hist_reg[0];
            for (int i = 1; i < msf_pkg::MACD_DLY; i++)
                macd_dly_reg[i] <= macd_dly_reg[i - 1];
        end
    end

    msf_dot u_sig_dot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (mctl_reg),
        .vals    (macd_vals),
        .weights (msf_pkg::WEIGHTS_SIGNAL),
        .ctl_out (sdot_ctl),
        .num     (sig_num)
    );

    msf_div u_sig_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (sdot_ctl),
        .num     (sig_num),
        .den     (msf_pkg::DEN_SIGNAL[sdot_ctl.count]),
        .ctl_out (sdiv_ctl),
        .quot    (sig_avg)
    );

    assign results.valid        = sdiv_ctl.valid;
    assign results.macd_value   = macd_dly_reg[msf_pkg::MACD_DLY - 1];
    assign results.signal_value = msf_pkg::PRICE_W'(sig_avg);

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= msf_pkg::CNT_W'(msf_pkg::COUNT_CAP))
        else $error("sample count above cap");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> count_reg != '0)
        else $error("sample count zero after accepted request");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(count_reg) && $stable(mctl_reg))
        else $error("pipeline moved while stalled");

    a_macd_store: assert property (@(posedge clk) disable iff (!rst_n)
        en && fdiv_ctl.valid |=> macd_hist_reg[0] == $past(macd_next))
        else $error("MACD history missed a value");

    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> sdiv_ctl.count != '0)
        else $error("result with empty window");

endmodule
